@@ src/thi_pkg.sv @@
// shared types and constants for the terrain height interpolator
// used by thi_ctrl, thi_datapath and terrain_height_interpolator_unit; no dependencies
package thi_pkg;

    localparam int POS_FRAC_BITS   = 8;
    localparam int POS_W           = 16;
    localparam int CELL_W          = POS_W - POS_FRAC_BITS;
    localparam int VTX_ADDR_W      = 16;
    localparam int VTX_H_W         = 10;
    localparam int DIM_W           = 9;
    localparam int SCALE_W         = 20;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 8;
    localparam int HEIGHT_W        = 22;
    localparam int WEIGHT_W        = POS_FRAC_BITS + 1;
    localparam int ACC_W           = VTX_H_W + WEIGHT_W - 1;
    localparam int PROD_W          = ACC_W + SCALE_W;
    localparam int RND_SHIFT       = POS_FRAC_BITS + SCALE_FRAC_BITS - OUT_FRAC_BITS;

    localparam int S_DATA_W        = 72;
    localparam int M_DATA_W        = 24;
    localparam int CFG_IDX_W       = 2;

    localparam logic [DIM_W-1:0]    STRIDE_RESET = 9'd256;
    localparam logic [DIM_W-1:0]    COUNT_RESET  = 9'd256;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 20'd8566;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 22'h3FFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;

    // action codes carried on s_tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // which of the three triangle corners is read or weighted
    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2
    } thi_corner_t;

    typedef struct packed {
        logic        capture;
        logic        calc_addr;
        logic        load_we;
        thi_corner_t rd_sel;
        logic        mac_en;
        logic        mac_clear;
        thi_corner_t mac_sel;
        logic        mul_en;
        logic        out_load;
    } thi_cmd_t;

    typedef struct packed {
        logic off_grid;
    } thi_status_t;

endpackage

@@ src/terrain_height_interpolator_unit.sv @@
// terrain height interpolator top level: stream ports, config port, controller and datapath
// depends on thi_pkg, thi_ctrl and thi_datapath
//   s_ channel carries load and query items; s_tuser selects the action
//   (0 load a vertex height, 1 query a position). a load writes red+green+blue
//   into the height store at vertex_addr; it gives no result.
//   a query splits the grid cell on its diagonal, blends the three corner
//   heights with barycentric weights, scales by height_scale, rounds and
//   saturates, and gives one result on the m_ channel.
//   a query occupies the block through these steps in order: the input
//   transfer, address calculation, three reads of the single-port height
//   memory (one corner per cycle), the last accumulate, the scaling multiply
//   and the output load. an off-grid query skips the reads and ends with
//   out_of_range set and height 0. the output register holds one finished
//   result; while it waits on m_tready the block still takes loads and
//   starts the next query, which then waits in its last step until the
//   register frees up. configuration writes on cfg_ are always taken and
//   must happen only while the block is idle. aresetn (synchronous, active
//   low) empties the output, returns the config registers to their defaults
//   and leaves the height store unwritten; vertices must be loaded before
//   they are queried.
module terrain_height_interpolator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vertex_addr[15:0], red[23:16], green[31:24], blue[39:32],
    // pos_x[55:40], pos_z[71:56]
    input  logic [thi_pkg::S_DATA_W-1:0]        s_tdata,
    // action[0]
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // height[21:0], zero[23:22]
    output logic [thi_pkg::M_DATA_W-1:0]        m_tdata,
    // out_of_range[0]
    output logic                                m_tuser,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thi_pkg::SCALE_W-1:0]         cfg_data
);

    thi_pkg::thi_cmd_t            cmd;
    thi_pkg::thi_status_t         status;
    logic [thi_pkg::HEIGHT_W-1:0] height;
    logic                         out_of_range;

    // config registers accept a transfer every cycle
    assign cfg_ready = 1'b1;

    thi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    thi_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .vertex_addr  (s_tdata[15:0]),
        .red          (s_tdata[23:16]),
        .green        (s_tdata[31:24]),
        .blue         (s_tdata[39:32]),
        .pos_x        (s_tdata[55:40]),
        .pos_z        (s_tdata[71:56]),
        .height       (height),
        .out_of_range (out_of_range)
    );

    // pack the result, upper bits padded with zeros
    assign m_tdata = {{(thi_pkg::M_DATA_W - thi_pkg::HEIGHT_W){1'b0}}, height};
    assign m_tuser = out_of_range;

endmodule

@@ src/thi_ctrl.sv @@
// controller state machine: sequences loads, address calculation, reads and scaling
// depends on thi_pkg
module thi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  thi_pkg::thi_status_t status,
    output thi_pkg::thi_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MAC2,
        ST_SCALE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   s_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = thi_pkg::CORNER_A;
        cmd.mac_sel   = thi_pkg::CORNER_A;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == thi_pkg::ACT_QUERY) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_ADDR;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_RD0;
            end
            ST_RD0: begin
                if (status.off_grid) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_sel = thi_pkg::CORNER_A;
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                cmd.rd_sel    = thi_pkg::CORNER_B;
                cmd.mac_en    = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_sel   = thi_pkg::CORNER_A;
                state_next    = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_sel  = thi_pkg::CORNER_C;
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = thi_pkg::CORNER_B;
                state_next  = ST_MAC2;
            end
            ST_MAC2: begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = thi_pkg::CORNER_C;
                state_next  = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.mul_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/thi_datapath.sv @@
// datapath: configuration registers, height memory, address unit, weighted sum, scaling
// depends on thi_pkg; driven by thi_ctrl commands
module thi_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  thi_pkg::thi_cmd_t                    cmd,
    output thi_pkg::thi_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [thi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [thi_pkg::SCALE_W-1:0]          cfg_data,
    input  logic [thi_pkg::VTX_ADDR_W-1:0]       vertex_addr,
    input  logic [7:0]                           red,
    input  logic [7:0]                           green,
    input  logic [7:0]                           blue,
    input  logic [thi_pkg::POS_W-1:0]            pos_x,
    input  logic [thi_pkg::POS_W-1:0]            pos_z,
    output logic [thi_pkg::HEIGHT_W-1:0]         height,
    output logic                                 out_of_range
);

    localparam int CW  = thi_pkg::CELL_W;
    localparam int FW  = thi_pkg::POS_FRAC_BITS;
    localparam int DW  = thi_pkg::DIM_W;
    localparam int AW  = thi_pkg::VTX_ADDR_W;
    localparam int WW  = thi_pkg::WEIGHT_W;
    localparam int BW  = CW + DW;
    localparam int FAW = BW + 1;
    localparam int TW  = thi_pkg::VTX_H_W + WW;
    localparam int RW  = thi_pkg::PROD_W + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << FW;

    // configuration
    logic [DW-1:0]                stride_reg, count_reg;
    logic [thi_pkg::SCALE_W-1:0]  scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= thi_pkg::STRIDE_RESET;
            count_reg  <= thi_pkg::COUNT_RESET;
            scale_reg  <= thi_pkg::SCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                thi_pkg::CFG_ROW_STRIDE:   stride_reg <= cfg_data[DW-1:0];
                thi_pkg::CFG_ROW_COUNT:    count_reg  <= cfg_data[DW-1:0];
                thi_pkg::CFG_HEIGHT_SCALE: scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // query position
    logic [thi_pkg::POS_W-1:0] px_reg, pz_reg;
    logic [CW-1:0]             cell_x, cell_z;
    logic [FW-1:0]             fx, fz;
    logic [WW-1:0]             fsum;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= pos_x;
            pz_reg <= pos_z;
        end
    end

    assign cell_x = px_reg[thi_pkg::POS_W-1:FW];
    assign cell_z = pz_reg[thi_pkg::POS_W-1:FW];
    assign fx     = px_reg[FW-1:0];
    assign fz     = pz_reg[FW-1:0];
    assign fsum   = WW'(fx) + WW'(fz);

    // cell address and grid check
    logic [BW-1:0]  base_full;
    logic [FAW-1:0] far_full;
    logic           off_grid;
    logic [AW-1:0]  base_reg;
    logic           off_grid_reg, upper_reg;

    always_comb begin
        base_full = BW'(BW'(cell_z) * BW'(stride_reg)) + BW'(cell_x);
        far_full  = FAW'(base_full) + FAW'(stride_reg) + FAW'(1);
        off_grid  = ((DW'(cell_x) + DW'(1)) >= stride_reg)
                 || ((DW'(cell_z) + DW'(1)) >= count_reg)
                 || (far_full[FAW-1:AW] != '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_addr) begin
            base_reg     <= base_full[AW-1:0];
            off_grid_reg <= off_grid;
            upper_reg    <= (fsum > ONE);
        end
    end

    assign status.off_grid = off_grid_reg;

    // corner addresses: lower triangle uses base, base+1, base+stride;
    // upper triangle uses base+1, base+stride, base+stride+1
    logic [AW-1:0] rd_addr;

    always_comb begin
        case (cmd.rd_sel)
            thi_pkg::CORNER_A:
                rd_addr = upper_reg ? (base_reg + AW'(1)) : base_reg;
            thi_pkg::CORNER_B:
                rd_addr = upper_reg ? (base_reg + AW'(stride_reg)) : (base_reg + AW'(1));
            thi_pkg::CORNER_C:
                rd_addr = upper_reg ? (base_reg + AW'(stride_reg) + AW'(1))
                                    : (base_reg + AW'(stride_reg));
            default:
                rd_addr = base_reg;
        endcase
    end

    // height memory, single port
    logic [thi_pkg::VTX_H_W-1:0] vtx_mem [0:(1 << AW)-1];
    logic [thi_pkg::VTX_H_W-1:0] rdata_reg;
    logic [thi_pkg::VTX_H_W-1:0] load_sum;

    assign load_sum = thi_pkg::VTX_H_W'(red) + thi_pkg::VTX_H_W'(green)
                    + thi_pkg::VTX_H_W'(blue);

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            vtx_mem[vertex_addr] <= load_sum;
        end else begin
            rdata_reg <= vtx_mem[rd_addr];
        end
    end

    // barycentric weight for the corner being accumulated
    logic [WW-1:0] weight;

    always_comb begin
        case (cmd.mac_sel)
            thi_pkg::CORNER_A:
                weight = upper_reg ? (ONE - WW'(fz)) : (ONE - fsum);
            thi_pkg::CORNER_B:
                weight = upper_reg ? (ONE - WW'(fx)) : WW'(fx);
            thi_pkg::CORNER_C:
                weight = upper_reg ? (fsum - ONE) : WW'(fz);
            default:
                weight = '0;
        endcase
    end

    // multiply-accumulate over the three corners
    logic [thi_pkg::ACC_W-1:0]  acc_reg;
    logic [TW-1:0]              term;
    logic [TW-1:0]              acc_sum;
    logic [thi_pkg::PROD_W-1:0] prod_reg;

    assign term    = TW'(rdata_reg) * TW'(weight);
    assign acc_sum = (cmd.mac_clear ? TW'(0) : TW'(acc_reg)) + term;

    always_ff @(posedge aclk) begin
        if (cmd.mac_en) begin
            acc_reg <= acc_sum[thi_pkg::ACC_W-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= thi_pkg::PROD_W'(acc_reg) * thi_pkg::PROD_W'(scale_reg);
        end
    end

    // round half up, saturate, and hold the result
    logic [RW-1:0]                        rnd;
    logic [RW-thi_pkg::RND_SHIFT-1:0]     shifted;
    logic [thi_pkg::HEIGHT_W-1:0]         sat;
    logic [thi_pkg::HEIGHT_W-1:0]         height_reg;
    logic                                 oor_reg;

    always_comb begin
        rnd     = RW'(prod_reg) + (RW'(1) << (thi_pkg::RND_SHIFT - 1));
        shifted = rnd[RW-1:thi_pkg::RND_SHIFT];
        if (shifted > (RW - thi_pkg::RND_SHIFT)'(thi_pkg::HEIGHT_MAX)) begin
            sat = thi_pkg::HEIGHT_MAX;
        end else begin
            sat = shifted[thi_pkg::HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            height_reg <= off_grid_reg ? '0 : sat;
            oor_reg    <= off_grid_reg;
        end
    end

    assign height       = height_reg;
    assign out_of_range = oor_reg;

endmodule
